FILE: rtl/b64lf_pkg.sv
// Shared types and constants for the line-framed Base64 encoder.
// Holds the queue entry type, character slot numbering and the alphabet lookup.
// No dependencies.
package b64lf_pkg;

	// character slots of one job, emitted lowest first
	localparam int NUM_SLOTS   = 9;
	localparam int SLOT_OPEN   = 0;
	localparam int SLOT_CHAR0  = 1;
	localparam int SLOT_CHAR1  = 2;
	localparam int SLOT_CHAR2  = 3;
	localparam int SLOT_CHAR3  = 4;
	localparam int SLOT_CLOSE  = 5;
	localparam int SLOT_COMMA  = 6;
	localparam int SLOT_NL     = 7;
	localparam int SLOT_REOPEN = 8;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_PAD   = 8'h3d;

	localparam logic [11:0] LINE_LENGTH_RST = 12'd256;

	typedef logic [NUM_SLOTS-1:0] slot_mask_t;
	typedef logic [3:0]           slot_idx_t;

	// one queued job: which slots to emit, the four block characters, end of message
	typedef struct packed {
		slot_mask_t      mask;
		logic [3:0][7:0] chars;
		logic            fin;
	} job_t;

	// standard Base64 alphabet
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return w + 8'd65;
		else if (v < 6'd52)
			return w + 8'd71;
		else if (v < 6'd62)
			return w - 8'd4;
		else if (v == 6'd62)
			return 8'h2b;
		else
			return 8'h2f;
	endfunction

endpackage

FILE: rtl/b64lf_front.sv
// Front end: accepts bytes, tracks group, line and message state, builds jobs.
// Depends on b64lf_pkg.
module b64lf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [11:0]          cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	output logic                 push_valid,
	input  logic                 push_ready,
	output b64lf_pkg::job_t      push_job
);
	import b64lf_pkg::*;

	logic [11:0]     line_length_q;
	logic [1:0][7:0] held_q;
	logic [1:0]      pos_q;
	logic [9:0]      blocks_q;
	logic            start_q;

	logic [1:0] pos;
	logic       emit, fin, brk, accept;
	logic [7:0] b0, b1, b2;
	logic [9:0] blocks_next;

	always_comb begin
		pos = (pos_q == 2'd3) ? 2'd2 : pos_q;
		emit = (pos == 2'd2) || final_byte;
		fin  = emit && final_byte;
		blocks_next = blocks_q + 10'd1;
		brk  = emit && !final_byte && (blocks_next >= line_length_q[11:2]);
		case (pos)
			2'd0: begin
				b0 = data_byte; b1 = 8'd0; b2 = 8'd0;
			end
			2'd1: begin
				b0 = held_q[0]; b1 = data_byte; b2 = 8'd0;
			end
			default: begin
				b0 = held_q[0]; b1 = held_q[1]; b2 = data_byte;
			end
		endcase

		push_job.mask = '0;
		push_job.mask[SLOT_OPEN]   = start_q;
		push_job.mask[SLOT_CHAR0]  = emit;
		push_job.mask[SLOT_CHAR1]  = emit;
		push_job.mask[SLOT_CHAR2]  = emit;
		push_job.mask[SLOT_CHAR3]  = emit;
		push_job.mask[SLOT_CLOSE]  = fin || brk;
		push_job.mask[SLOT_COMMA]  = brk;
		push_job.mask[SLOT_NL]     = brk;
		push_job.mask[SLOT_REOPEN] = brk;
		push_job.chars[0] = b64_char(b0[7:2]);
		push_job.chars[1] = b64_char({b0[1:0], b1[7:4]});
		push_job.chars[2] = (pos != 2'd0) ? b64_char({b1[3:0], b2[7:6]}) : CH_PAD;
		push_job.chars[3] = (pos == 2'd2) ? b64_char(b2[5:0]) : CH_PAD;
		push_job.fin = fin;
	end

	// queue space is required even for a byte that is only held
	assign in_ready   = push_ready;
	assign push_valid = in_valid && (start_q || emit);
	assign accept     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RST;
			pos_q         <= 2'd0;
			blocks_q      <= 10'd0;
			start_q       <= 1'b1;
			held_q        <= '0;
		end else begin
			if (cfg_wr_en)
				line_length_q <= cfg_wr_data;
			if (accept) begin
				start_q <= fin;
				if (emit) begin
					pos_q <= 2'd0;
				end else begin
					pos_q          <= pos + 2'd1;
					held_q[pos[0]] <= data_byte;
				end
				if (fin || brk)
					blocks_q <= 10'd0;
				else if (emit)
					blocks_q <= blocks_next;
			end
		end
	end

endmodule

FILE: rtl/b64lf_queue.sv
// Short job queue between front and back end.
// Depends on b64lf_pkg.
module b64lf_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  b64lf_pkg::job_t push_job,
	output logic            pop_valid,
	input  logic            pop_ready,
	output b64lf_pkg::job_t pop_job
);
	import b64lf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

FILE: rtl/b64lf_back.sv
// Back end: walks the slots of each job, one character a cycle while the receiver takes them, into the output register.
// Depends on b64lf_pkg.
module b64lf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  b64lf_pkg::job_t pop_job,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_char,
	output logic            run_last,
	output logic            message_done
);
	import b64lf_pkg::*;

	slot_mask_t      rem_q;
	logic [3:0][7:0] chars_q;
	logic            fin_q;
	logic            out_valid_q, run_last_q, done_q;
	logic [7:0]      char_q;

	slot_mask_t rem_next;
	slot_idx_t  idx;
	logic       active, out_load, emitting, do_pop;
	logic [7:0] ch;

	always_comb begin
		idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i])
				idx = slot_idx_t'(i);
		end
		rem_next = rem_q;
		rem_next[idx] = 1'b0;
		case (idx)
			slot_idx_t'(SLOT_OPEN):   ch = CH_QUOTE;
			slot_idx_t'(SLOT_CHAR0):  ch = chars_q[0];
			slot_idx_t'(SLOT_CHAR1):  ch = chars_q[1];
			slot_idx_t'(SLOT_CHAR2):  ch = chars_q[2];
			slot_idx_t'(SLOT_CHAR3):  ch = chars_q[3];
			slot_idx_t'(SLOT_CLOSE):  ch = CH_QUOTE;
			slot_idx_t'(SLOT_COMMA):  ch = CH_COMMA;
			slot_idx_t'(SLOT_NL):     ch = CH_NL;
			slot_idx_t'(SLOT_REOPEN): ch = CH_QUOTE;
			default:                  ch = CH_QUOTE;
		endcase
	end

	assign active    = (rem_q != '0);
	assign out_load  = !out_valid_q || out_ready;
	assign emitting  = active && out_load;
	// next job loads as the last character of the current one goes out
	assign pop_ready = !active || (emitting && rem_next == '0);
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pop)
				rem_q <= pop_job.mask;
			else if (emitting)
				rem_q <= rem_next;
			if (emitting)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			chars_q <= pop_job.chars;
			fin_q   <= pop_job.fin;
		end
		if (emitting) begin
			char_q     <= ch;
			run_last_q <= (rem_next == '0);
			done_q     <= fin_q && (idx == slot_idx_t'(SLOT_CLOSE));
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = char_q;
	assign run_last     = run_last_q;
	assign message_done = done_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> run_last_q)
		else $error("message end not flagged as last of its item");

	a_done_is_quote: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> char_q == CH_QUOTE)
		else $error("message end on a character other than the closing quote");

	a_pop_loads_work: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> rem_q != '0)
		else $error("job taken from queue with nothing to emit");

endmodule

FILE: rtl/base64_line_framed_encoder.sv
// Top level of the line-framed Base64 encoder.
// Depends on b64lf_pkg, b64lf_front, b64lf_queue and b64lf_back.
//
// Usage
//   Input channel (in_valid/in_ready, data_byte, final_byte): one message byte
//   per item, final_byte set on the last byte of a message.
//   Output channel (out_valid/out_ready, out_char, run_last, message_done): one
//   character per item. run_last marks the last character caused by an input
//   byte, message_done the closing quote of a message.
//   cfg_wr_en/cfg_wr_data: writes line_length (reset 256); a line holds
//   line_length/4 blocks, below 4 every block is its own line.
//   Write it only while the encoder is idle.
// Timing
//   The front end takes a byte every cycle while the job queue has room.
//   A job passes from the queue via the slot registers to the output register.
//   The back end emits one character per cycle while the receiver takes them,
//   so throughput is bounded by output characters: 4/3 per byte plus quotes and
//   line breaks; held bytes only cost a queue check.
// Reset and stall
//   Reset clears group, line and message state and empties the queue;
//   line_length returns to 256. A stalled receiver holds the output register,
//   the back end stops, the queue fills and then in_ready drops.
module base64_line_framed_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [11:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        run_last,
	output logic        message_done
);
	import b64lf_pkg::*;

	// front to queue
	logic push_valid, push_ready;
	job_t push_job;
	// queue to back
	logic pop_valid, pop_ready;
	job_t pop_job;

	// classifies each byte, keeps the partial group and line position
	b64lf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_job    (push_job)
	);

	// decouples byte intake from character output
	b64lf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// serialises quotes, block characters and line breaks
	b64lf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_job      (pop_job),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.run_last     (run_last),
		.message_done (message_done)
	);

endmodule

FILE: tb/sv/base64_line_framed_encoder_tb.sv
// Self-checking testbench for base64_line_framed_encoder: a directed table, then random messages.
// Each accepted byte is run through a local encoder model; every character is checked against it or a typed row.
// Depends on b64lf_pkg and the encoder RTL.
module base64_line_framed_encoder_tb;
	import b64lf_pkg::*;

	// one expected output character
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       done;
	} enc_char_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	localparam string B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam string PREDICTED       = "*";
	localparam int    NUM_PHASES      = 8;
	localparam int    ITEMS_PER_PHASE = 47;
	localparam int    RANDOM_PHASE    = 6;   // line length drawn at random
	localparam int    PRESSURE_PHASE  = 2;   // receiver holds off for a long stretch
	localparam int    HOLD_CYCLES     = 400;
	localparam int    SETTLE_CYCLES   = 8;   // wait before a line length write
	localparam int unsigned PHASE_LEN [NUM_PHASES] = '{4095, 0, 3, 4, 12, 8, 0, 256};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [11:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        final_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_char;
	logic        run_last;
	logic        message_done;

	base64_line_framed_encoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.final_byte   (final_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.run_last     (run_last),
		.message_done (message_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard limit on the whole run, far beyond the slowest legal run.
	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Encoder model state: a copy of what the block should hold.
	// ------------------------------------------------------------------
	logic [11:0] line_len;
	logic [7:0]  held [2];
	logic [1:0]  grp_pos;
	logic [9:0]  blocks_on_line;
	logic        at_start;

	enc_char_t   pending_chars[$];   // characters still owed by the block
	enc_char_t   want;

	int          fail_count    = 0;
	int          bytes_sent    = 0;
	int          chars_checked = 0;
	int          settings_seen = 0;

	// idling knobs, written by the main sequence
	int          snd_idle_pct  = 0;
	int          rcv_stall_pct = 0;
	bit          pressure_on   = 1'b0;
	bit          pressure_done = 1'b0;
	int          hold_left     = 0;

	// directed table
	row_kind_t   dir_kind[$];
	int unsigned dir_val[$];
	logic        dir_fin[$];
	string       dir_exp[$];

	function automatic void model_reset();
		line_len       = LINE_LENGTH_RST;
		held[0]        = '0;
		held[1]        = '0;
		grp_pos        = '0;
		blocks_on_line = '0;
		at_start       = 1'b1;
	endfunction

	// Works out the characters caused by one byte and advances the model.
	function automatic void encode_byte(input logic [7:0] b, input logic fin,
			output enc_char_t res[$]);
		logic [7:0] b0, b1, b2;
		int         len;
		res = {};
		if (at_start) begin
			res.push_back('{CH_QUOTE, 1'b0, 1'b0});
			at_start = 1'b0;
		end
		if (grp_pos < 2 && !fin) begin
			held[grp_pos[0]] = b;
			grp_pos          = grp_pos + 2'd1;
		end else begin
			case (grp_pos)
				2'd0: begin b0 = b;       b1 = '0;      b2 = '0; len = 1; end
				2'd1: begin b0 = held[0]; b1 = b;       b2 = '0; len = 2; end
				default: begin b0 = held[0]; b1 = held[1]; b2 = b; len = 3; end
			endcase
			res.push_back('{B64_ALPHABET[b0[7:2]], 1'b0, 1'b0});
			res.push_back('{B64_ALPHABET[{b0[1:0], b1[7:4]}], 1'b0, 1'b0});
			res.push_back('{(len > 1) ? B64_ALPHABET[{b1[3:0], b2[7:6]}] : CH_PAD,
				1'b0, 1'b0});
			res.push_back('{(len > 2) ? B64_ALPHABET[b2[5:0]] : CH_PAD, 1'b0, 1'b0});
			blocks_on_line = blocks_on_line + 10'd1;
			grp_pos        = '0;
			held[0]        = '0;
			held[1]        = '0;
			if (fin) begin
				res.push_back('{CH_QUOTE, 1'b0, 1'b1});
				blocks_on_line = '0;
				at_start       = 1'b1;
			end else if (blocks_on_line >= line_len[11:2]) begin
				// line full (or a shortened line already past its end)
				res.push_back('{CH_QUOTE, 1'b0, 1'b0});
				res.push_back('{CH_COMMA, 1'b0, 1'b0});
				res.push_back('{CH_NL,    1'b0, 1'b0});
				res.push_back('{CH_QUOTE, 1'b0, 1'b0});
				blocks_on_line = '0;
			end
		end
		if (res.size() > 0)
			res[res.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Sender: every call starts just after a rising edge. in_valid is only
	// lowered when a gap follows, so a back-to-back item never sees it
	// dropped and raised in the same step.
	// ------------------------------------------------------------------
	task automatic offer_byte(input logic [7:0] b, input logic fin, input string typed);
		enc_char_t res[$];
		int        n_gap;
		n_gap = 0;
		while (n_gap < 20 && $urandom_range(0, 99) < snd_idle_pct)
			n_gap++;
		if (n_gap > 0) begin
			in_valid <= 1'b0;
			repeat (n_gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		// item taken at this edge
		bytes_sent++;
		encode_byte(b, fin, res);
		if (typed == PREDICTED) begin
			foreach (res[i])
				pending_chars.push_back(res[i]);
		end else begin
			// hand-written expectation: last character ends the run, and the
			// closing quote of a final byte ends the message
			for (int i = 0; i < typed.len(); i++)
				pending_chars.push_back('{typed[i], i == typed.len() - 1,
					fin && i == typed.len() - 1});
		end
	endtask

	// Drain the block, let it settle, then write line_length.
	task automatic write_line_length(input logic [11:0] v);
		in_valid <= 1'b0;
		while (pending_chars.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		line_len  = v;
		settings_seen++;
	endtask

	task automatic add_row(input row_kind_t k, input int unsigned v, input logic f,
			input string e);
		dir_kind.push_back(k);
		dir_val.push_back(v);
		dir_fin.push_back(f);
		dir_exp.push_back(e);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off counted here so the
	// job queue fills and in_ready drops while the sender keeps offering.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (pressure_on && !pressure_done) begin
			hold_left     = HOLD_CYCLES;
			pressure_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	// Checker: each character taken is compared with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character: out_char %h run_last %b message_done %b",
					out_char, run_last, message_done);
				fail_count++;
			end else begin
				want = pending_chars.pop_front();
				chars_checked++;
				if (out_char !== want.ch) begin
					$error("out_char: expected %h, got %h", want.ch, out_char);
					fail_count++;
				end
				if (run_last !== want.last) begin
					$error("run_last: expected %b, got %b", want.last, run_last);
					fail_count++;
				end
				if (message_done !== want.done) begin
					$error("message_done: expected %b, got %b", want.done, message_done);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [7:0]  b;
		int          msg_left;
		int          r;
		logic [11:0] len;

		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		data_byte   <= '0;
		final_byte  <= 1'b0;
		out_ready   <= 1'b0;
		model_reset();
		msg_left = 0;

		// Directed table. Rows with a typed string are plain to read off the
		// encoding; "*" rows are left to the model.
		// single bytes after reset, both extremes, default line length
		add_row(ROW_BYTE, 8'h00, 1'b1, "\"AA==\"");
		add_row(ROW_BYTE, 8'hFF, 1'b1, "\"/w==\"");
		// full group of ones
		add_row(ROW_BYTE, 8'hFF, 1'b0, "\"");
		add_row(ROW_BYTE, 8'hFF, 1'b0, "");
		add_row(ROW_BYTE, 8'hFF, 1'b1, "////\"");
		// two-byte final group, one pad
		add_row(ROW_BYTE, 8'h00, 1'b0, "\"");
		add_row(ROW_BYTE, 8'h00, 1'b1, "AAA=\"");
		// a message left open over three blocks, then the line shortened under it
		add_row(ROW_BYTE, 8'hFB, 1'b0, "\"");
		add_row(ROW_BYTE, 8'hEF, 1'b0, "");
		add_row(ROW_BYTE, 8'hBE, 1'b0, "++++");
		add_row(ROW_BYTE, 8'h00, 1'b0, "");
		add_row(ROW_BYTE, 8'h00, 1'b0, "");
		add_row(ROW_BYTE, 8'h00, 1'b0, "AAAA");
		add_row(ROW_BYTE, 8'h00, 1'b0, "");
		add_row(ROW_BYTE, 8'h00, 1'b0, "");
		add_row(ROW_BYTE, 8'h00, 1'b0, "AAAA");
		add_row(ROW_CFG,  8,     1'b0, "");
		add_row(ROW_BYTE, 8'h10, 1'b0, PREDICTED);
		add_row(ROW_BYTE, 8'h20, 1'b0, PREDICTED);
		add_row(ROW_BYTE, 8'h30, 1'b0, PREDICTED);
		add_row(ROW_BYTE, 8'h01, 1'b1, PREDICTED);
		// zero blocks per line: every block closes its own line
		add_row(ROW_CFG,  0,     1'b0, "");
		add_row(ROW_BYTE, 8'h00, 1'b0, "\"");
		add_row(ROW_BYTE, 8'h00, 1'b0, "");
		add_row(ROW_BYTE, 8'h00, 1'b0, "AAAA\",\n\"");
		add_row(ROW_BYTE, 8'hFF, 1'b1, "/w==\"");

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_kind[i]) begin
			if (dir_kind[i] == ROW_CFG)
				write_line_length(dir_val[i][11:0]);
			else
				offer_byte(dir_val[i][7:0], dir_fin[i], dir_exp[i]);
		end

		// Random messages over several line lengths and idling patterns.
		// A phase may end mid-message, so the next setting lands mid-line.
		for (int p = 0; p < NUM_PHASES; p++) begin
			len = (p == RANDOM_PHASE) ? 12'($urandom_range(0, 40)) : PHASE_LEN[p][11:0];
			write_line_length(len);
			case (idle_mode_t'(p % 4))
				IDLE_NONE:     begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				IDLE_SENDER:   begin snd_idle_pct = 58; rcv_stall_pct = 0;  end
				IDLE_RECEIVER: begin snd_idle_pct = 0;  rcv_stall_pct = 58; end
				default:       begin snd_idle_pct = 26; rcv_stall_pct = 26; end
			endcase
			pressure_on = (p == PRESSURE_PHASE);
			for (int i = 0; i < ITEMS_PER_PHASE || (p == NUM_PHASES - 1 && msg_left > 0);
					i++) begin
				if (msg_left == 0) begin
					// mostly short messages, now and then long ones for many lines
					r = $urandom_range(0, 19);
					if (r < 16)
						msg_left = $urandom_range(1, 9);
					else if (r < 19)
						msg_left = $urandom_range(10, 30);
					else
						msg_left = $urandom_range(31, 60);
				end
				case ($urandom_range(0, 9))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				offer_byte(b, msg_left == 1, PREDICTED);
				msg_left--;
			end
			pressure_on = 1'b0;
		end

		in_valid <= 1'b0;
		while (pending_chars.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d bytes and %0d characters over %0d line length writes,",
			bytes_sent, chars_checked, settings_seen);
		$display("with sender gaps, receiver stalls and one long output hold-off");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
